>>> hw/rtl/mau_pkg.sv
// Package for the modular arithmetic unit: widths, operation codes, reset modulus.
// No dependencies; every other file of the block imports it.
`default_nettype none
package mau_pkg;
   localparam int MOD_WIDTH = 31;
   localparam int EXP_WIDTH = 32;
   localparam int MODE_WIDTH = 3;
   localparam int SER_WIDTH = 32;
   localparam int SER_CNT_WIDTH = $clog2(SER_WIDTH);
   localparam int EXP_CNT_WIDTH = $clog2(EXP_WIDTH + 1);

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(1000000007);

   localparam logic [MODE_WIDTH-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_NEG = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_POW = 3'd5;

   typedef logic [MOD_WIDTH-1:0] mod_type;
   typedef logic [EXP_WIDTH-1:0] exp_type;
   typedef logic [MODE_WIDTH-1:0] mode_type;
endpackage
`default_nettype wire

>>> hw/rtl/mau_req_if.sv
// Request and response channel interfaces of the modular arithmetic unit.
// Depends on mau_pkg.
`default_nettype none
interface mau_req_if import mau_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type mode;
   mod_type  operand_a;
   exp_type  operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if import mau_pkg::*; ();
   logic    valid;
   logic    ready;
   mod_type result;
   logic    no_inverse;
   modport source (output valid, result, no_inverse, input ready);
   modport sink (input valid, result, no_inverse, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/modular_arith_unit_top.sv
// Modular arithmetic unit: add, sub, mul, div (extended Euclid), neg, pow mod a modulus.
// Depends on mau_pkg and the channel interfaces in mau_req_if.sv.
//
//   channel | dir | payload                          | handshake
//   req     | in  | mode, operand_a, operand_b       | valid/ready
//   rsp     | out | result, no_inverse               | valid/ready
//   csr     | in  | csr_wdata (modulus)              | csr_we
//
// One shared shift/add/reduce unit serves every modular multiply, operand
// reduction and Euclid division.
// req.ready is high only when idle; the result holds in rsp until taken.
// Synchronous reset clears control state and sets the modulus to 1000000007.
`default_nettype none
module modular_arith_unit_top import mau_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   mau_req_if.sink       req,
   mau_rsp_if.source     rsp,
   input  wire logic     csr_we,
   input  wire mod_type  csr_wdata
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SER  = 4'd1;
   localparam logic [3:0] ST_RA   = 4'd2;
   localparam logic [3:0] ST_RB   = 4'd3;
   localparam logic [3:0] ST_MULR = 4'd4;
   localparam logic [3:0] ST_EUT  = 4'd5;
   localparam logic [3:0] ST_EUQ  = 4'd6;
   localparam logic [3:0] ST_EUU  = 4'd7;
   localparam logic [3:0] ST_PWT  = 4'd8;
   localparam logic [3:0] ST_PWM  = 4'd9;
   localparam logic [3:0] ST_PWQ  = 4'd10;
   localparam logic [3:0] ST_PWS  = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   mod_type modulus_ff, modulus_in;
   mode_type mode_ff, mode_in;
   logic [SER_WIDTH-1:0] x_ff, x_in, q_ff, q_in;
   logic [SER_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [EXP_CNT_WIDTH-1:0] ecnt_ff, ecnt_in;
   mod_type r_ff, r_in, y_ff, y_in, a_ff, a_in, g_ff, g_in, h_ff, h_in;
   mod_type s_ff, s_in, w_ff, w_in, res_ff, res_in;
   exp_type e_ff, e_in;
   logic sel_h_ff, sel_h_in, flag_ff, flag_in;

   mod_type one_mod, cur_mod;
   logic [SER_WIDTH-1:0] addend;
   logic [SER_WIDTH:0] t_sum, m1, m2, t_red;
   logic [SER_WIDTH-1:0] sum_ab, dif_ab;

   assign one_mod = (modulus_ff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
   assign cur_mod = sel_h_ff ? h_ff : modulus_ff;
   assign addend  = x_ff[SER_WIDTH-1] ? {1'b0, y_ff} : '0;
   assign t_sum   = {1'b0, r_ff, 1'b0} + {1'b0, addend};
   assign m1      = {2'b0, cur_mod};
   assign m2      = {1'b0, cur_mod, 1'b0};

   always_comb begin
      priority if (t_sum >= m2) begin
         t_red = t_sum - m2;
      end else if (t_sum >= m1) begin
         t_red = t_sum - m1;
      end else begin
         t_red = t_sum;
      end
   end

   assign sum_ab = {1'b0, a_ff} + {1'b0, r_ff};
   assign dif_ab = {1'b0, a_ff} + {1'b0, modulus_ff} - {1'b0, r_ff};

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; modulus_in = modulus_ff; mode_in = mode_ff;
      x_in = x_ff; q_in = q_ff; cnt_in = cnt_ff; ecnt_in = ecnt_ff; r_in = r_ff;
      y_in = y_ff; a_in = a_ff; g_in = g_ff; h_in = h_ff; s_in = s_ff; w_in = w_ff;
      res_in = res_ff; e_in = e_ff; sel_h_in = sel_h_ff; flag_in = flag_ff;
      if (csr_we) begin
         modulus_in = csr_wdata;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               e_in    = req.operand_b;
               res_in  = '0;
               flag_in = 1'b0;
               if (modulus_ff == '0 || req.mode > MODE_POW) begin
                  state_in = ST_OUT;
               end else begin
                  x_in = {1'b0, req.operand_a}; y_in = MOD_WIDTH'(1); r_in = '0;
                  cnt_in = '0; sel_h_in = 1'b0; ret_in = ST_RA; state_in = ST_SER;
               end
            end
         end
         ST_SER: begin
            r_in   = t_red[MOD_WIDTH-1:0];
            q_in   = {q_ff[SER_WIDTH-2:0], t_sum >= m1};
            x_in   = {x_ff[SER_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ret_ff;
            end
         end
         ST_RA: begin
            a_in = r_ff;
            x_in = e_ff; y_in = MOD_WIDTH'(1); r_in = '0; cnt_in = '0;
            ret_in = ST_RB; state_in = ST_SER;
         end
         ST_RB: begin
            unique case (mode_ff)
               MODE_ADD: begin
                  res_in = (sum_ab >= {1'b0, modulus_ff}) ?
                     MOD_WIDTH'(sum_ab - {1'b0, modulus_ff}) : MOD_WIDTH'(sum_ab);
                  state_in = ST_OUT;
               end
               MODE_SUB: begin
                  res_in = (a_ff >= r_ff) ? a_ff - r_ff : MOD_WIDTH'(dif_ab);
                  state_in = ST_OUT;
               end
               MODE_NEG: begin
                  res_in = (a_ff != '0) ? modulus_ff - a_ff : '0;
                  state_in = ST_OUT;
               end
               MODE_MUL: begin
                  x_in = {1'b0, a_ff}; y_in = r_ff; r_in = '0; cnt_in = '0;
                  ret_in = ST_MULR; state_in = ST_SER;
               end
               MODE_DIV: begin
                  g_in = r_ff; h_in = modulus_ff; s_in = one_mod; w_in = '0;
                  state_in = ST_EUT;
               end
               default: begin
                  a_in = a_ff; s_in = one_mod; ecnt_in = '0; state_in = ST_PWT;
               end
            endcase
         end
         ST_MULR: begin
            res_in = r_ff; state_in = ST_OUT;
         end
         ST_EUT: begin
            if (h_ff == '0) begin
               if (g_ff == MOD_WIDTH'(1)) begin
                  x_in = {1'b0, a_ff}; y_in = s_ff; r_in = '0; cnt_in = '0;
                  sel_h_in = 1'b0; ret_in = ST_MULR; state_in = ST_SER;
               end else begin
                  res_in = '0; flag_in = 1'b1; state_in = ST_OUT;
               end
            end else begin
               x_in = {1'b0, g_ff}; y_in = MOD_WIDTH'(1); r_in = '0; cnt_in = '0;
               sel_h_in = 1'b1; ret_in = ST_EUQ; state_in = ST_SER;
            end
         end
         ST_EUQ: begin
            g_in = h_ff; h_in = r_ff;
            x_in = q_ff; y_in = w_ff; r_in = '0; cnt_in = '0;
            sel_h_in = 1'b0; ret_in = ST_EUU; state_in = ST_SER;
         end
         ST_EUU: begin
            s_in = w_ff;
            w_in = (s_ff >= r_ff) ? s_ff - r_ff :
               MOD_WIDTH'({1'b0, s_ff} + {1'b0, modulus_ff} - {1'b0, r_ff});
            state_in = ST_EUT;
         end
         ST_PWT: begin
            if (ecnt_ff == EXP_CNT_WIDTH'(EXP_WIDTH)) begin
               res_in = s_ff; state_in = ST_OUT;
            end else if (e_ff[0]) begin
               x_in = {1'b0, s_ff}; y_in = a_ff; r_in = '0; cnt_in = '0;
               ret_in = ST_PWM; state_in = ST_SER;
            end else begin
               state_in = ST_PWQ;
            end
         end
         ST_PWM: begin
            s_in = r_ff; state_in = ST_PWQ;
         end
         ST_PWQ: begin
            x_in = {1'b0, a_ff}; y_in = a_ff; r_in = '0; cnt_in = '0;
            ret_in = ST_PWS; state_in = ST_SER;
         end
         ST_PWS: begin
            a_in = r_ff; e_in = e_ff >> 1; ecnt_in = ecnt_ff + 1'b1; state_in = ST_PWT;
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         modulus_ff <= MODULUS_RESET;
         sel_h_ff   <= 1'b0;
         cnt_ff     <= '0;
         ecnt_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         modulus_ff <= modulus_in;
         sel_h_ff   <= sel_h_in;
         cnt_ff     <= cnt_in;
         ecnt_ff    <= ecnt_in;
      end
      mode_ff <= mode_in; x_ff <= x_in; q_ff <= q_in; r_ff <= r_in; y_ff <= y_in;
      a_ff <= a_in; g_ff <= g_in; h_ff <= h_in; s_ff <= s_in; w_ff <= w_in;
      res_ff <= res_in; e_ff <= e_in; flag_ff <= flag_in;
   end

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = (state_ff == ST_OUT);
   assign rsp.result     = res_ff;
   assign rsp.no_inverse = flag_ff;

`ifndef SYNTHESIS
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.no_inverse |-> rsp.result == '0)
      else $error("no_inverse with nonzero result");
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && modulus_ff != '0 |-> rsp.result < modulus_ff)
      else $error("result not reduced");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("ready while busy");
   a_flag_div: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.no_inverse |-> mode_ff == MODE_DIV)
      else $error("no_inverse outside divide");
`endif
endmodule
`default_nettype wire
